### hdl/dpw_pkg.sv
package dpw_pkg;

  localparam int ROT_FRAC_BITS_DEF = 14;
  localparam int MID_DEPTH_DEF     = 4;
  localparam int OUT_DEPTH         = 2;
  localparam int LOCAL_FRAC        = 2;
  localparam int LOCAL_LIM_BITS    = 31;

  localparam int REG_W     = 22;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = 12;
  localparam int ROW_W     = 12;
  localparam int DEPTH_W   = 16;
  localparam int QUAT_W    = 16;
  localparam int POS_W     = 24;
  localparam int WORLD_W   = 32;

  localparam logic [REG_W-1:0] FOCAL_X_RST  = 22'd357299;
  localparam logic [REG_W-1:0] FOCAL_Y_RST  = 22'd359562;
  localparam logic [REG_W-1:0] CENTER_X_RST = 22'd347213;
  localparam logic [REG_W-1:0] CENTER_Y_RST = 22'd181709;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y
  } reg_index_t;

  typedef enum logic {
    MODE_POSE  = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    POSE_IDLE,
    POSE_MUL,
    POSE_NUM,
    POSE_LOAD,
    POSE_DIV,
    POSE_STORE
  } pose_state_t;

  typedef struct packed {
    logic [REG_W-1:0] focal_x;
    logic [REG_W-1:0] focal_y;
    logic [REG_W-1:0] center_x;
    logic [REG_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    mode_t                     mode;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
    logic [DEPTH_W-1:0]        depth_mm;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
  } item_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
  } point_t;

  typedef struct packed {
    logic adv;
    logic empty;
  } pipe_status_t;

endpackage

### hdl/depth_pixel_to_world_point_unit.sv
// Channel   Handshake        Payload
// input     push / full      mode, pixel_col, pixel_row, depth_mm, quat_*, pos_*
// result    empty / pop      world_x, world_y, world_z
// config    cfg_we           cfg_index, cfg_data
//
// A depth pixel reaches the result queue through the point pipeline; the two per-pixel
// dividers, one quotient bit a stage, make up most of its stages. Pixels flow one a cycle
// while the result queue keeps up and no pose request is in progress.
// A pose request waits for the pipeline to drain; the serial divider then forms the nine
// matrix entries one after another.
// Reset is synchronous; a full result queue stalls the whole point pipeline.
module depth_pixel_to_world_point_unit #(
  parameter int ROT_FRAC_BITS = dpw_pkg::ROT_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH   = dpw_pkg::MID_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode,
  input  logic [dpw_pkg::COL_W-1:0]          pixel_col,
  input  logic [dpw_pkg::ROW_W-1:0]          pixel_row,
  input  logic [dpw_pkg::DEPTH_W-1:0]        depth_mm,
  input  logic signed [dpw_pkg::QUAT_W-1:0]  quat_x,
  input  logic signed [dpw_pkg::QUAT_W-1:0]  quat_y,
  input  logic signed [dpw_pkg::QUAT_W-1:0]  quat_z,
  input  logic signed [dpw_pkg::QUAT_W-1:0]  quat_w,
  input  logic signed [dpw_pkg::POS_W-1:0]   pos_x,
  input  logic signed [dpw_pkg::POS_W-1:0]   pos_y,
  input  logic signed [dpw_pkg::POS_W-1:0]   pos_z,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [dpw_pkg::WORLD_W-1:0] world_x,
  output logic signed [dpw_pkg::WORLD_W-1:0] world_y,
  output logic signed [dpw_pkg::WORLD_W-1:0] world_z,
  input  logic                               cfg_we,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpw_pkg::REG_W-1:0]          cfg_data
);

  localparam int IW = $bits(dpw_pkg::item_t);
  localparam int OW = $bits(dpw_pkg::point_t);

  dpw_pkg::cfg_t         cfg;
  dpw_pkg::item_t        fr_item;
  dpw_pkg::item_t        head;
  dpw_pkg::point_t       pt;
  dpw_pkg::point_t       res;
  dpw_pkg::pipe_status_t st;
  logic                  fr_push;
  logic                  mq_full;
  logic                  mq_empty;
  logic                  mq_pop;
  logic [IW-1:0]         mq_data;
  logic                  pix_go;
  logic                  pose_go;
  logic                  pose_busy;
  logic                  op_push;
  logic                  oq_full;
  logic [OW-1:0]         oq_data;
  logic signed [ROT_FRAC_BITS+1:0]  rot [9];
  logic signed [dpw_pkg::POS_W-1:0] trans [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= dpw_pkg::FOCAL_X_RST;
      cfg.focal_y  <= dpw_pkg::FOCAL_Y_RST;
      cfg.center_x <= dpw_pkg::CENTER_X_RST;
      cfg.center_y <= dpw_pkg::CENTER_Y_RST;
    end else if (cfg_we) begin
      unique case (dpw_pkg::reg_index_t'(cfg_index))
        dpw_pkg::REG_FOCAL_X:  cfg.focal_x  <= cfg_data;
        dpw_pkg::REG_FOCAL_Y:  cfg.focal_y  <= cfg_data;
        dpw_pkg::REG_CENTER_X: cfg.center_x <= cfg_data;
        dpw_pkg::REG_CENTER_Y: cfg.center_y <= cfg_data;
      endcase
    end
  end

  dpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .depth_mm  (depth_mm),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .q_full    (mq_full),
    .q_push    (fr_push),
    .q_item    (fr_item)
  );

  dpw_queue #(
    .W     (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_push),
    .wdata (fr_item),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_data),
    .empty (mq_empty)
  );

  // A pose request is issued only into an empty point pipeline, so that earlier
  // pixels see the old pose and later ones the new.
  assign head    = dpw_pkg::item_t'(mq_data);
  assign pix_go  = !mq_empty && head.mode == dpw_pkg::MODE_PIXEL && !pose_busy && st.adv;
  assign pose_go = !mq_empty && head.mode == dpw_pkg::MODE_POSE && !pose_busy && st.empty;
  assign mq_pop  = pix_go || pose_go;

  dpw_pose #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_pose (
    .clk   (clk),
    .rst   (rst),
    .start (pose_go),
    .item  (head),
    .busy  (pose_busy),
    .rot   (rot),
    .trans (trans)
  );

  dpw_pixel #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_pixel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (pix_go),
    .item      (head),
    .rot       (rot),
    .trans     (trans),
    .status    (st),
    .out_full  (oq_full),
    .out_push  (op_push),
    .out_point (pt)
  );

  dpw_queue #(
    .W     (OW),
    .DEPTH (dpw_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (pt),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_data),
    .empty (empty)
  );

  assign res     = dpw_pkg::point_t'(oq_data);
  assign world_x = res.world_x;
  assign world_y = res.world_y;
  assign world_z = res.world_z;

  a_pose_drained: assert property (@(posedge clk) disable iff (rst)
    pose_busy |-> st.empty)
    else $error("point pipeline active during a pose update");

  a_pose_starts: assert property (@(posedge clk) disable iff (rst)
    pose_go |=> pose_busy)
    else $error("pose request issued but pose unit not busy");

  a_no_pixel_issue: assert property (@(posedge clk) disable iff (rst)
    $past(pose_go) |-> !$past(pix_go))
    else $error("pixel and pose issued together");

endmodule

### hdl/dpw_queue.sv
module dpw_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/dpw_front.sv
module dpw_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             mode,
  input  logic [dpw_pkg::COL_W-1:0]        pixel_col,
  input  logic [dpw_pkg::ROW_W-1:0]        pixel_row,
  input  logic [dpw_pkg::DEPTH_W-1:0]      depth_mm,
  input  logic signed [dpw_pkg::QUAT_W-1:0] quat_x,
  input  logic signed [dpw_pkg::QUAT_W-1:0] quat_y,
  input  logic signed [dpw_pkg::QUAT_W-1:0] quat_z,
  input  logic signed [dpw_pkg::QUAT_W-1:0] quat_w,
  input  logic signed [dpw_pkg::POS_W-1:0]  pos_x,
  input  logic signed [dpw_pkg::POS_W-1:0]  pos_y,
  input  logic signed [dpw_pkg::POS_W-1:0]  pos_z,
  input  logic                             q_full,
  output logic                             q_push,
  output dpw_pkg::item_t                   q_item
);

  logic           hold;
  logic           accept;
  logic           keep;
  dpw_pkg::item_t held;

  // A pixel of zero depth causes nothing, so it is dropped here.
  assign keep   = (dpw_pkg::mode_t'(mode) == dpw_pkg::MODE_POSE) || (depth_mm != '0);
  assign full   = hold && q_full;
  assign accept = push && !full;
  assign q_push = hold && !q_full;
  assign q_item = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (accept) begin
      hold <= keep;
    end else if (q_push) begin
      hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held.mode      <= dpw_pkg::mode_t'(mode);
      held.pixel_col <= pixel_col;
      held.pixel_row <= pixel_row;
      held.depth_mm  <= depth_mm;
      held.quat_x    <= quat_x;
      held.quat_y    <= quat_y;
      held.quat_z    <= quat_z;
      held.quat_w    <= quat_w;
      held.pos_x     <= pos_x;
      held.pos_y     <= pos_y;
      held.pos_z     <= pos_z;
    end
  end

endmodule

### hdl/dpw_pose.sv
module dpw_pose #(
  parameter int ROT_FRAC_BITS = dpw_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  dpw_pkg::item_t                    item,
  output logic                              busy,
  output logic signed [ROT_FRAC_BITS+1:0]   rot [9],
  output logic signed [dpw_pkg::POS_W-1:0]  trans [3]
);

  localparam int F   = ROT_FRAC_BITS;
  localparam int RW  = F + 2;
  localparam int PW  = 2 * dpw_pkg::QUAT_W;
  localparam int NW  = PW + 3;
  localparam int DDW = PW + 1;
  localparam int DW  = NW + F;
  localparam int SCW = $clog2(F + 1);

  dpw_pkg::pose_state_t state, state_next;

  logic signed [dpw_pkg::QUAT_W-1:0] qx, qy, qz, qw;
  logic signed [PW-1:0] sxx, syy, szz, sww, pxy, pwz, pxz, pwy, pyz, pwx;
  logic signed [NW-1:0] nm [9];
  logic signed [NW-1:0] nm_c [9];
  logic [DDW-1:0]       dd;
  logic [DDW-1:0]       dsum;
  logic [3:0]           idx;
  logic [SCW-1:0]       step;
  logic [DDW-1:0]       rem;
  logic [F:0]           low;
  logic                 sgn;
  logic signed [NW-1:0] sel;
  logic [NW-1:0]        mg;
  logic [DW-1:0]        dvd;
  logic [DDW:0]         t;
  logic                 ge;

  assign dsum = {1'b0, sxx} + {1'b0, syy} + {1'b0, szz} + {1'b0, sww};

  always_comb begin
    nm_c[0] = NW'(sww) + NW'(sxx) - NW'(syy) - NW'(szz);
    nm_c[1] = (NW'(pxy) - NW'(pwz)) <<< 1;
    nm_c[2] = (NW'(pxz) + NW'(pwy)) <<< 1;
    nm_c[3] = (NW'(pxy) + NW'(pwz)) <<< 1;
    nm_c[4] = NW'(sww) - NW'(sxx) + NW'(syy) - NW'(szz);
    nm_c[5] = (NW'(pyz) - NW'(pwx)) <<< 1;
    nm_c[6] = (NW'(pxz) - NW'(pwy)) <<< 1;
    nm_c[7] = (NW'(pyz) + NW'(pwx)) <<< 1;
    nm_c[8] = NW'(sww) - NW'(sxx) - NW'(syy) + NW'(szz);
  end

  assign sel = nm[idx];
  assign mg  = (sel < 0) ? NW'(-sel) : NW'(sel);
  assign dvd = (DW'(mg) << F) + DW'(dd >> 1);
  assign t   = {rem, low[F]};
  assign ge  = t >= {1'b0, dd};

  always_comb begin
    state_next = state;
    unique case (state)
      dpw_pkg::POSE_IDLE:  if (start) state_next = dpw_pkg::POSE_MUL;
      dpw_pkg::POSE_MUL:   state_next = dpw_pkg::POSE_NUM;
      dpw_pkg::POSE_NUM:   state_next = (dsum == '0) ? dpw_pkg::POSE_IDLE : dpw_pkg::POSE_LOAD;
      dpw_pkg::POSE_LOAD:  state_next = dpw_pkg::POSE_DIV;
      dpw_pkg::POSE_DIV:   if (step == SCW'(F)) state_next = dpw_pkg::POSE_STORE;
      dpw_pkg::POSE_STORE: state_next = (idx == 4'd8) ? dpw_pkg::POSE_IDLE : dpw_pkg::POSE_LOAD;
      default:             state_next = dpw_pkg::POSE_IDLE;
    endcase
  end

  always_comb begin
    busy = state != dpw_pkg::POSE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpw_pkg::POSE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        rot[i] <= (i % 4 == 0) ? ({{(RW-1){1'b0}}, 1'b1} << F) : '0;
      end
      for (int i = 0; i < 3; i++) begin
        trans[i] <= '0;
      end
    end else begin
      if (state == dpw_pkg::POSE_IDLE && start) begin
        trans[0] <= item.pos_x;
        trans[1] <= item.pos_y;
        trans[2] <= item.pos_z;
      end
      if (state == dpw_pkg::POSE_NUM && dsum == '0) begin
        for (int i = 0; i < 9; i++) begin
          rot[i] <= (i % 4 == 0) ? ({{(RW-1){1'b0}}, 1'b1} << F) : '0;
        end
      end
      if (state == dpw_pkg::POSE_STORE) begin
        rot[idx] <= sgn ? -$signed({1'b0, low}) : $signed({1'b0, low});
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dpw_pkg::POSE_IDLE: begin
        qx  <= item.quat_x;
        qy  <= item.quat_y;
        qz  <= item.quat_z;
        qw  <= item.quat_w;
        idx <= '0;
      end
      dpw_pkg::POSE_MUL: begin
        sxx <= qx * qx;
        syy <= qy * qy;
        szz <= qz * qz;
        sww <= qw * qw;
        pxy <= qx * qy;
        pwz <= qw * qz;
        pxz <= qx * qz;
        pwy <= qw * qy;
        pyz <= qy * qz;
        pwx <= qw * qx;
      end
      dpw_pkg::POSE_NUM: begin
        nm <= nm_c;
        dd <= dsum;
      end
      dpw_pkg::POSE_LOAD: begin
        rem  <= DDW'(dvd >> (F + 1));
        low  <= dvd[F:0];
        sgn  <= sel < 0;
        step <= '0;
      end
      dpw_pkg::POSE_DIV: begin
        rem  <= ge ? DDW'(t - {1'b0, dd}) : t[DDW-1:0];
        low  <= {low[F-1:0], ge};
        step <= step + 1'b1;
      end
      dpw_pkg::POSE_STORE: begin
        idx <= idx + 1'b1;
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule

### hdl/dpw_pixel.sv
module dpw_pixel #(
  parameter int ROT_FRAC_BITS = dpw_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dpw_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  dpw_pkg::item_t                    item,
  input  logic signed [ROT_FRAC_BITS+1:0]   rot [9],
  input  logic signed [dpw_pkg::POS_W-1:0]  trans [3],
  output dpw_pkg::pipe_status_t             status,
  input  logic                              out_full,
  output logic                              out_push,
  output dpw_pkg::point_t                   out_point
);

  localparam int F    = ROT_FRAC_BITS;
  localparam int RW   = F + 2;
  localparam int RG   = dpw_pkg::REG_W;
  localparam int ZW   = dpw_pkg::DEPTH_W;
  localparam int NXW  = RG + 2;
  localparam int PRW  = NXW + ZW + 1;
  localparam int DVW  = PRW + dpw_pkg::LOCAL_FRAC + 1;
  localparam int PW   = dpw_pkg::LOCAL_LIM_BITS + 2;
  localparam int MW   = RW + PW;
  localparam int SW   = MW + 2;
  localparam int RDW  = SW - F - 1;
  localparam int WW   = dpw_pkg::WORLD_W;
  localparam int ST_C = 3 + DVW;
  localparam int NST  = ST_C + 5;
  localparam logic [DVW-1:0] PLIM = {{(DVW-1){1'b0}}, 1'b1} << dpw_pkg::LOCAL_LIM_BITS;
  localparam logic signed [RDW:0] WMAX = {{(RDW+1-WW){1'b0}}, 1'b0, {(WW-1){1'b1}}};
  localparam logic signed [RDW:0] WMIN = {{(RDW+2-WW){1'b1}}, {(WW-1){1'b0}}};

  logic [NST-1:0] vld;
  logic           adv;

  logic [RG-1:0]         fd [2];
  logic signed [NXW-1:0] nx [2];
  logic [ZW-1:0]         z1, z2;
  logic signed [PRW-1:0] pr [2];
  logic [PRW-1:0]        pmag [2];

  logic [RG-1:0]  drem [2][DVW+1];
  logic [DVW-1:0] ddq  [2][DVW+1];
  logic           dsg  [2][DVW+1];
  logic [ZW-1:0]  dz   [DVW+1];
  logic [RG-1:0]  nrem [2][DVW];
  logic           nbit [2][DVW];

  logic signed [PW-1:0] pc   [3];
  logic signed [PW-1:0] pc_c [3];
  logic signed [MW-1:0] mp [9];
  logic signed [SW-1:0] ss [3];
  logic signed [RDW-1:0] rd [3];
  logic signed [RDW-1:0] rd_c [3];
  logic signed [RDW:0]  ow_c [3];
  logic signed [WW-1:0] ow [3];

  assign fd[0] = (cfg.focal_x == '0) ? RG'(1) : cfg.focal_x;
  assign fd[1] = (cfg.focal_y == '0) ? RG'(1) : cfg.focal_y;

  assign adv          = !(vld[NST-1] && out_full);
  assign status.adv   = adv;
  assign status.empty = vld == '0;
  assign out_push     = vld[NST-1] && !out_full;

  assign out_point.world_x = ow[0];
  assign out_point.world_y = ow[1];
  assign out_point.world_z = ow[2];

  always_comb begin
    logic [RG:0] t;
    for (int l = 0; l < 2; l++) begin
      pmag[l] = (pr[l] < 0) ? PRW'(-pr[l]) : PRW'(pr[l]);
      for (int k = 0; k < DVW; k++) begin
        t = {drem[l][k], ddq[l][k][DVW-1]};
        nbit[l][k] = t >= {1'b0, fd[l]};
        nrem[l][k] = nbit[l][k] ? RG'(t - {1'b0, fd[l]}) : t[RG-1:0];
      end
    end
  end

  always_comb begin
    logic [DVW-1:0] q;
    logic [PW-2:0]  cl;
    for (int l = 0; l < 2; l++) begin
      q = ddq[l][DVW];
      cl = (q > PLIM) ? PLIM[PW-2:0] : q[PW-2:0];
      pc_c[l] = dsg[l][DVW] ? -$signed({1'b0, cl}) : $signed({1'b0, cl});
    end
    pc_c[2] = PW'($signed({1'b0, dz[DVW], {dpw_pkg::LOCAL_FRAC{1'b0}}}));
  end

  always_comb begin
    logic [SW-1:0] m;
    logic [SW-1:0] rq;
    for (int i = 0; i < 3; i++) begin
      m  = (ss[i] < 0) ? SW'(-ss[i]) : SW'(ss[i]);
      rq = (m + (SW'(1) << (F + 1))) >> (F + 2);
      rd_c[i] = (ss[i] < 0) ? -$signed(RDW'(rq)) : $signed(RDW'(rq));
      ow_c[i] = (RDW+1)'(rd[i]) + (RDW+1)'(trans[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx[0] <= $signed({2'b00, item.pixel_col, 10'b0}) - $signed({2'b00, cfg.center_x});
      nx[1] <= $signed({2'b00, item.pixel_row, 10'b0}) - $signed({2'b00, cfg.center_y});
      z1    <= item.depth_mm;

      for (int l = 0; l < 2; l++) begin
        pr[l] <= PRW'(nx[l]) * PRW'($signed({1'b0, z1}));
      end
      z2 <= z1;

      for (int l = 0; l < 2; l++) begin
        drem[l][0] <= '0;
        ddq[l][0]  <= (DVW'(pmag[l]) << dpw_pkg::LOCAL_FRAC) + DVW'(fd[l] >> 1);
        dsg[l][0]  <= pr[l] < 0;
        for (int k = 0; k < DVW; k++) begin
          drem[l][k+1] <= nrem[l][k];
          ddq[l][k+1]  <= {ddq[l][k][DVW-2:0], nbit[l][k]};
          dsg[l][k+1]  <= dsg[l][k];
        end
      end
      dz[0] <= z2;
      for (int k = 0; k < DVW; k++) begin
        dz[k+1] <= dz[k];
      end

      pc <= pc_c;

      for (int i = 0; i < 9; i++) begin
        mp[i] <= MW'(rot[i]) * MW'(pc[i % 3]);
      end

      for (int i = 0; i < 3; i++) begin
        ss[i] <= SW'(mp[3*i]) + SW'(mp[3*i+1]) + SW'(mp[3*i+2]);
      end

      rd <= rd_c;

      for (int i = 0; i < 3; i++) begin
        if (ow_c[i] > WMAX) begin
          ow[i] <= WMAX[WW-1:0];
        end else if (ow_c[i] < WMIN) begin
          ow[i] <= WMIN[WW-1:0];
        end else begin
          ow[i] <= ow_c[i][WW-1:0];
        end
      end
    end
  end

endmodule
